// ===== design/ibsc_pkg.sv =====
// Shared types, constants and helper functions of the infrared beacon smoothing classifier.
`default_nettype none
package ibsc_pkg;

	// The smoothing divisor is a power of two, so the decay and rise divide by shifting.
	localparam int SMOOTH_SHIFT = 2;
	localparam int SMOOTH_DIV   = 1 << SMOOTH_SHIFT;
	localparam int SUM_W        = 8 + SMOOTH_SHIFT;

	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int ADDR_W       = 5;
	localparam int REG_IDX_W    = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ABSENT    = 3'd0,
		REG_RESERVED  = 3'd1,
		REG_RED_BIT   = 3'd2,
		REG_GREEN_BIT = 3'd3,
		REG_FIELD_BIT = 3'd4,
		REG_THRESHOLD = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		RGN_NOWHERE     = 4'd0,
		RGN_RED         = 4'd1,
		RGN_GREEN       = 4'd2,
		RGN_FIELD       = 4'd3,
		RGN_RED_GREEN   = 4'd4,
		RGN_RED_FIELD   = 4'd5,
		RGN_GREEN_FIELD = 4'd6,
		RGN_ALL         = 4'd7,
		RGN_NONE_YET    = 4'd8
	} region_t;

	typedef struct packed {
		logic [7:0] absent_code;
		logic [7:0] reserved_pattern;
		logic [7:0] red_bit;
		logic [7:0] green_bit;
		logic [7:0] field_bit;
		logic [7:0] presence_threshold;
	} cfg_t;

	// Which beams the accepted byte reports as seen.
	typedef struct packed {
		logic red;
		logic green;
		logic field;
	} seen_t;

	function automatic logic [7:0] smooth(input logic [7:0] avg, input logic seen);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(avg) * SUM_W'(SMOOTH_DIV - 1) + SUM_W'(8'hFF);
		if (seen) begin
			return 8'(sum >> SMOOTH_SHIFT);
		end
		return avg >> SMOOTH_SHIFT;
	endfunction

	function automatic region_t classify(input logic r, input logic g, input logic f);
		priority if (r && g && f) return RGN_ALL;
		else if (r && g) return RGN_RED_GREEN;
		else if (r && f) return RGN_RED_FIELD;
		else if (g && f) return RGN_GREEN_FIELD;
		else if (r) return RGN_RED;
		else if (g) return RGN_GREEN;
		else if (f) return RGN_FIELD;
		else return RGN_NOWHERE;
	endfunction

endpackage
`default_nettype wire

// ===== design/ibsc_cfg.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none
module ibsc_cfg (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [ibsc_pkg::ADDR_W-1:0]  paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output ibsc_pkg::cfg_t               cfg
);

	ibsc_pkg::cfg_t cfg_q;
	logic           wr_en;
	ibsc_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = ibsc_pkg::reg_idx_t'(paddr[ibsc_pkg::ADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.absent_code        <= 8'd255;
			cfg_q.reserved_pattern   <= 8'd240;
			cfg_q.red_bit            <= 8'd8;
			cfg_q.green_bit          <= 8'd4;
			cfg_q.field_bit          <= 8'd2;
			cfg_q.presence_threshold <= 8'd96;
		end else if (wr_en) begin
			unique case (idx)
				ibsc_pkg::REG_ABSENT:    cfg_q.absent_code        <= pwdata[7:0];
				ibsc_pkg::REG_RESERVED:  cfg_q.reserved_pattern   <= pwdata[7:0];
				ibsc_pkg::REG_RED_BIT:   cfg_q.red_bit            <= pwdata[7:0];
				ibsc_pkg::REG_GREEN_BIT: cfg_q.green_bit          <= pwdata[7:0];
				ibsc_pkg::REG_FIELD_BIT: cfg_q.field_bit          <= pwdata[7:0];
				ibsc_pkg::REG_THRESHOLD: cfg_q.presence_threshold <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (idx)
			ibsc_pkg::REG_ABSENT:    prdata = {24'd0, cfg_q.absent_code};
			ibsc_pkg::REG_RESERVED:  prdata = {24'd0, cfg_q.reserved_pattern};
			ibsc_pkg::REG_RED_BIT:   prdata = {24'd0, cfg_q.red_bit};
			ibsc_pkg::REG_GREEN_BIT: prdata = {24'd0, cfg_q.green_bit};
			ibsc_pkg::REG_FIELD_BIT: prdata = {24'd0, cfg_q.field_bit};
			ibsc_pkg::REG_THRESHOLD: prdata = {24'd0, cfg_q.presence_threshold};
			default:                 prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/ibsc_front.sv =====
// Front end: checks each beacon byte and decides which beams it reports as seen.
`default_nettype none
module ibsc_front (
	input  wire  [7:0]            beacon_byte,
	input  ibsc_pkg::cfg_t        cfg,
	output ibsc_pkg::seen_t       seen
);

	logic valid_code;

	assign valid_code = (beacon_byte != cfg.absent_code) &&
		((beacon_byte & cfg.reserved_pattern) == cfg.reserved_pattern);

	assign seen.red   = valid_code && ((beacon_byte & cfg.red_bit) != 8'd0);
	assign seen.green = valid_code && ((beacon_byte & cfg.green_bit) != 8'd0);
	assign seen.field = valid_code && ((beacon_byte & cfg.field_bit) != 8'd0);

endmodule
`default_nettype wire

// ===== design/ibsc_queue.sv =====
// Short queue of classified words between the front end and the back end.
`default_nettype none
module ibsc_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  ibsc_pkg::seen_t       push_data,
	output logic                  full,
	input  wire                   pop,
	output ibsc_pkg::seen_t       pop_data,
	output logic                  not_empty
);

	ibsc_pkg::seen_t                 mem_q [ibsc_pkg::QUEUE_DEPTH];
	logic [ibsc_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [ibsc_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [ibsc_pkg::QCNT_W-1:0]     count_q;

	assign full      = (count_q == ibsc_pkg::QCNT_W'(ibsc_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ibsc_pkg::QPTR_W'(ibsc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == ibsc_pkg::QPTR_W'(ibsc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/ibsc_back.sv =====
// Back end: updates the three beam averages, classifies the region and holds the result word.
`default_nettype none
module ibsc_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  ibsc_pkg::seen_t       in_seen,
	output logic                  in_pop,
	input  wire  [7:0]            threshold,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [31:0]           out_data
);

	logic [7:0]        red_avg_q;
	logic [7:0]        green_avg_q;
	logic [7:0]        field_avg_q;
	ibsc_pkg::region_t region_q;
	logic              out_valid_q;
	logic [31:0]       out_data_q;

	logic [7:0]        red_nxt;
	logic [7:0]        green_nxt;
	logic [7:0]        field_nxt;
	ibsc_pkg::region_t region_nxt;

	// The output register frees up in the same cycle its word is taken.
	assign in_pop = in_valid && (!out_valid_q || out_ready);

	always_comb begin
		red_nxt    = ibsc_pkg::smooth(red_avg_q, in_seen.red);
		green_nxt  = ibsc_pkg::smooth(green_avg_q, in_seen.green);
		field_nxt  = ibsc_pkg::smooth(field_avg_q, in_seen.field);
		region_nxt = ibsc_pkg::classify(red_nxt > threshold, green_nxt > threshold,
			field_nxt > threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_avg_q   <= 8'd0;
			green_avg_q <= 8'd0;
			field_avg_q <= 8'd0;
			region_q    <= ibsc_pkg::RGN_NONE_YET;
			out_valid_q <= 1'b0;
		end else begin
			if (in_pop) begin
				red_avg_q   <= red_nxt;
				green_avg_q <= green_nxt;
				field_avg_q <= field_nxt;
				region_q    <= region_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			out_data_q <= {field_nxt, green_nxt, red_nxt, region_q, region_nxt};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

// ===== design/ir_beacon_smoothing_classifier_top.sv =====
// Top level of the infrared beacon smoothing classifier.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | s_tdata[7:0] beacon_byte
//  m_*     | out       | m_tvalid/m_tready  | m_tdata region_now, region_before, levels
//  APB     | in        | psel/penable       | paddr byte address 4*index, pwdata[7:0]
//
// One word is accepted per cycle while s_tready is high; it passes through the
// queue and then the output register; the three average registers close the back-end update loop.
// Reset clears the averages to zero and the previous region to "none yet".
// A stalled output fills the two-entry queue, after which s_tready drops.
`default_nettype none
module ir_beacon_smoothing_classifier_top (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [7:0]                   s_tdata,   // [7:0] beacon_byte
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// [3:0] region_now, [7:4] region_before, [15:8] red_level,
	// [23:16] green_level, [31:24] field_level
	output logic [31:0]                  m_tdata,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [ibsc_pkg::ADDR_W-1:0]  paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	ibsc_pkg::cfg_t  cfg;
	ibsc_pkg::seen_t front_seen;
	ibsc_pkg::seen_t back_seen;
	logic            q_full;
	logic            q_not_empty;
	logic            q_pop;
	logic            q_push;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	ibsc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ibsc_front u_front (
		.beacon_byte (s_tdata),
		.cfg         (cfg),
		.seen        (front_seen)
	);

	ibsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (front_seen),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (back_seen),
		.not_empty (q_not_empty)
	);

	ibsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_not_empty),
		.in_seen   (back_seen),
		.in_pop    (q_pop),
		.threshold (cfg.presence_threshold),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire
